// ===== hw/rtl/tama_pkg.sv =====
// Package for the three-axis moving-average filter.
// Shared widths, lane control and lane result types; no dependencies.
package tama_pkg;

    localparam int SAMPLE_W = 16;              // one axis sample / mean
    localparam int AXES     = 3;
    localparam int DATA_W   = SAMPLE_W * AXES; // packed x, y, z
    localparam int LEN_W    = 7;               // window length register

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    // per-cycle commands to every lane
    typedef struct packed {
        logic clear;     // drop the running sum
        logic sum_upd;   // add new sample, remove the overwritten one
        logic div_start; // load the divider from the running sum
    } lane_ctl_t;

    // what one lane hands to the merge stage
    typedef struct packed {
        logic                neg; // sum was negative
        logic [SAMPLE_W-1:0] quo; // |sum| / len, low bits
    } lane_res_t;

endpackage

// ===== hw/rtl/three_axis_moving_average.sv =====
// Top level of the three-axis boxcar moving-average filter.
// Instantiates tama_window, three tama_lane copies and tama_merge; uses tama_pkg.
//
//  channel   | dir | handshake                     | payload
//  ----------+-----+-------------------------------+-------------------------------
//  s_axis    | in  | s_axis_tvalid / s_axis_tready | mag_x, mag_y, mag_z (s16 each)
//  m_axis    | out | m_axis_tvalid / m_axis_tready | avg_x, avg_y, avg_z (s16 each)
//  cfg       | in  | cfg_wr_en (no wait)           | window_len (7 bits)
//
//  One sample transaction runs from accept through the sum update from the ring
//  read, the divider load, SUM_W bit-serial divide steps that run in parallel on
//  all three axes, a state that sees the dividers finish and the output register
//  load. The next sample is taken once the sequencer is back in idle.
//  Reset (rst_n, async, active low) sets window_len to min(MAX_WINDOW, 64) and
//  clears sums, write position and fill flag; no memory sweep is needed.
//  A result waiting in the output register does not block the next sample;
//  only loading a second result waits for the master side.
module three_axis_moving_average #(
    parameter int MAX_WINDOW = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [tama_pkg::DATA_W-1:0] s_axis_tdata,  // mag_x[15:0], mag_y[31:16], mag_z[47:32]
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [tama_pkg::DATA_W-1:0] m_axis_tdata,  // avg_x[15:0], avg_y[31:16], avg_z[47:32]
    input  logic                        cfg_wr_en,
    input  logic [tama_pkg::LEN_W-1:0]  cfg_wr_data    // window_len
);
    import tama_pkg::*;

    // sum of up to MAX_WINDOW signed 16-bit samples
    localparam int SUM_W = SAMPLE_W + $clog2(MAX_WINDOW);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,  // ready for a sample
        ST_SUM   = 5'b00010,  // old slot value available, update sums
        ST_START = 5'b00100,  // load dividers
        ST_DIV   = 5'b01000,  // dividers running
        ST_OUT   = 5'b10000   // wait for a free output register
    } state_t;

    state_t state_reg, state_next;

    logic              accept;
    logic              load;
    logic              can_load;
    logic              all_idle;
    logic [LEN_W-1:0]  len;
    logic [DATA_W-1:0] new_sample;
    logic [DATA_W-1:0] old_sample;
    lane_ctl_t         ctl;
    lane_res_t         lane_res [AXES];
    logic [AXES-1:0]   lane_busy;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign all_idle      = (lane_busy == '0);

    assign ctl.clear     = cfg_wr_en;
    assign ctl.sum_upd   = (state_reg == ST_SUM);
    assign ctl.div_start = (state_reg == ST_START);

    // sequencer: one sample in flight at a time
    always_comb
    begin
        state_next = state_reg;
        load       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_SUM;
            end
            ST_SUM:
            begin
                state_next = ST_START;
            end
            ST_START:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (all_idle)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (can_load)
                begin
                    load       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    tama_window #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_window (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .accept      (accept),
        .sample_in   (s_axis_tdata),
        .len         (len),
        .new_sample  (new_sample),
        .old_sample  (old_sample)
    );

    // one lane per axis, all stepped by the same commands
    for (genvar i = 0; i < AXES; i++)
    begin : g_lane
        tama_lane #(
            .SUM_W (SUM_W)
        ) u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (ctl),
            .new_val (new_sample[i*SAMPLE_W +: SAMPLE_W]),
            .old_val (old_sample[i*SAMPLE_W +: SAMPLE_W]),
            .len     (len),
            .busy    (lane_busy[i]),
            .res     (lane_res[i])
        );
    end

    tama_merge u_merge (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (load),
        .lane_res      (lane_res),
        .m_axis_tready (m_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tdata  (m_axis_tdata),
        .can_load      (can_load)
    );

endmodule

// ===== hw/rtl/tama_window.sv =====
// Sample ring for the moving-average filter: window length register,
// write position, fill flag and the sample memory. Uses tama_pkg.
module tama_window #(
    parameter int MAX_WINDOW = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [tama_pkg::LEN_W-1:0]  cfg_wr_data,
    input  logic                        accept,
    input  logic [tama_pkg::DATA_W-1:0] sample_in,
    output logic [tama_pkg::LEN_W-1:0]  len,
    output logic [tama_pkg::DATA_W-1:0] new_sample,
    output logic [tama_pkg::DATA_W-1:0] old_sample
);
    import tama_pkg::*;

    localparam int AW        = $clog2(MAX_WINDOW);
    localparam int RESET_LEN = (MAX_WINDOW < 64) ? MAX_WINDOW : 64;

    logic [LEN_W-1:0]  len_reg, len_next;
    logic [AW-1:0]     wp_reg, wp_next;
    logic              full_reg, full_next;
    logic              old_ok_reg;
    logic [DATA_W-1:0] sample_reg;
    logic [DATA_W-1:0] rd_reg;
    logic [AW:0]       wp_inc;

    logic [DATA_W-1:0] mem [MAX_WINDOW];

    always_comb
    begin
        len_next  = len_reg;
        wp_next   = wp_reg;
        full_next = full_reg;
        wp_inc    = {1'b0, wp_reg} + 1'b1;
        if (cfg_wr_en)
        begin
            // zero reads as one, anything past the ring depth saturates
            if (cfg_wr_data == '0)
                len_next = LEN_W'(1);
            else if (32'(cfg_wr_data) > MAX_WINDOW)
                len_next = LEN_W'(MAX_WINDOW);
            else
                len_next = cfg_wr_data;
            wp_next   = '0;
            full_next = 1'b0;
        end
        else if (accept)
        begin
            if (32'(wp_inc) >= 32'(len_reg))
            begin
                wp_next   = '0;
                full_next = 1'b1; // every slot below len now holds a sample
            end
            else
            begin
                wp_next = wp_inc[AW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg    <= LEN_W'(RESET_LEN);
            wp_reg     <= '0;
            full_reg   <= 1'b0;
            old_ok_reg <= 1'b0;
        end
        else
        begin
            len_reg  <= len_next;
            wp_reg   <= wp_next;
            full_reg <= full_next;
            if (accept)
                old_ok_reg <= full_reg;
        end
    end

    // read-first: the slot's previous sample comes out as the new one goes in
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_reg      <= mem[wp_reg];
            mem[wp_reg] <= sample_in;
            sample_reg  <= sample_in;
        end
    end

    assign len        = len_reg;
    assign new_sample = sample_reg;
    assign old_sample = old_ok_reg ? rd_reg : '0; // unfilled slot counts as zero

endmodule

// ===== hw/rtl/tama_lane.sv =====
// One axis lane: running window sum and a bit-serial restoring divider
// that divides the sum magnitude by the window length. Uses tama_pkg.
module tama_lane #(
    parameter int SUM_W = 22
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  tama_pkg::lane_ctl_t          ctl,
    input  tama_pkg::sample_t            new_val,
    input  tama_pkg::sample_t            old_val,
    input  logic [tama_pkg::LEN_W-1:0]   len,
    output logic                         busy,
    output tama_pkg::lane_res_t          res
);
    import tama_pkg::*;

    localparam int CW = $clog2(SUM_W + 1);

    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic signed [SAMPLE_W:0] diff;
    logic [SUM_W-1:0]        mag;
    logic                    busy_reg;
    logic [CW-1:0]           cnt_reg;
    logic [LEN_W-1:0]        rem_reg;
    logic [SUM_W-1:0]        quo_reg;
    logic                    neg_reg;
    logic [LEN_W:0]          rem_sh;
    logic                    ge;
    logic [LEN_W:0]          rem_sub;

    always_comb
    begin
        diff     = (SAMPLE_W+1)'(new_val) - (SAMPLE_W+1)'(old_val);
        sum_next = sum_reg + SUM_W'(diff);
        mag      = sum_reg[SUM_W-1] ? (~sum_reg + 1'b1) : sum_reg;
        rem_sh   = {rem_reg, quo_reg[SUM_W-1]};
        ge       = (rem_sh >= {1'b0, len});
        rem_sub  = rem_sh - {1'b0, len};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (ctl.clear)
                sum_reg <= '0;
            else if (ctl.sum_upd)
                sum_reg <= sum_next;

            if (ctl.div_start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(SUM_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                    busy_reg <= 1'b0;
                else
                    cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // divider datapath, one quotient bit per cycle while busy
    always_ff @(posedge clk)
    begin
        if (ctl.div_start)
        begin
            neg_reg <= sum_reg[SUM_W-1];
            quo_reg <= mag;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[SUM_W-2:0], ge};
            rem_reg <= ge ? rem_sub[LEN_W-1:0] : rem_sh[LEN_W-1:0];
        end
    end

    assign busy    = busy_reg;
    assign res.neg = neg_reg;
    assign res.quo = quo_reg[SAMPLE_W-1:0];

endmodule

// ===== hw/rtl/tama_merge.sv =====
// Merge stage: applies each lane's sign, packs x, y, z and holds the
// result in the output register until the master side takes it. Uses tama_pkg.
module tama_merge (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  tama_pkg::lane_res_t         lane_res [tama_pkg::AXES],
    input  logic                        m_axis_tready,
    output logic                        m_axis_tvalid,
    output logic [tama_pkg::DATA_W-1:0] m_axis_tdata,
    output logic                        can_load
);
    import tama_pkg::*;

    logic              valid_reg, valid_next;
    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] packed_res;

    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            // truncation toward zero: negate the magnitude quotient
            packed_res[i*SAMPLE_W +: SAMPLE_W] = lane_res[i].neg
                ? (~lane_res[i].quo + 1'b1) : lane_res[i].quo;
        end
        can_load   = !valid_reg || m_axis_tready;
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (m_axis_tready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= packed_res;
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = data_reg;

endmodule
